### rtl/ppe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppe_pkg: shared types and constants of the palette pixel expander
// Operation and alpha-mode codes, the command passed from front to back, and
// the result beat held in the output queue.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int CMD_DEPTH         = 4;
  localparam int RES_DEPTH         = 4;

  localparam logic [7:0] ALPHA_FULL = 8'hFF;
  localparam logic [7:0] ALPHA_NONE = 8'h00;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    MODE_OPAQUE       = 3'd0,
    MODE_SEPARATE     = 3'd1,
    MODE_SEP_INVERTED = 3'd2,
    MODE_PAL_INVERTED = 3'd3,
    MODE_PACKED       = 3'd4
  } alpha_mode_t;

  typedef struct packed {
    logic        is_pixel;
    logic        in_range;
    logic [7:0]  index;
    logic [31:0] entry;     // alpha, red, green, blue from high to low byte
    logic        use_pal;   // alpha comes from the inverted palette alpha
    logic [7:0]  alpha;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

### rtl/ppe_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppe_fifo: small register queue
// Show-ahead queue: the oldest entry is presented while empty is low.
// ----------------------------------------------------------------------------
module ppe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [WIDTH-1:0]             push_data,
  output logic                              full,
  input  wire logic                         pop,
  output logic [WIDTH-1:0]                  pop_data,
  output logic                              empty,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ppe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppe_front: input classification
// Holds the alpha-mode register and the packed-alpha bit counter, and turns
// each accepted beat into a palette write or a pixel command.
// ----------------------------------------------------------------------------
module ppe_front #(
  parameter int PALETTE_DEPTH = ppe_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          alpha_mode_we,
  input  wire logic [2:0]    alpha_mode_wdata,
  input  wire logic          accept,
  input  wire logic          operation,
  input  wire logic [7:0]    pixel_index,
  input  wire logic [7:0]    alpha_byte,
  input  wire logic [7:0]    entry_blue,
  input  wire logic [7:0]    entry_green,
  input  wire logic [7:0]    entry_red,
  input  wire logic [7:0]    entry_alpha,
  input  wire logic          last_pixel,
  output ppe_pkg::cmd_t      cmd
);

  ppe_pkg::alpha_mode_t alpha_mode;
  logic [2:0]           bit_position;
  logic [2:0]           bit_position_next;
  logic                 is_pixel;

  assign is_pixel = (ppe_pkg::op_t'(operation) == ppe_pkg::OP_PIXEL);

  always_comb begin
    cmd          = '0;
    cmd.is_pixel = is_pixel;
    cmd.in_range = ({1'b0, pixel_index} < 9'(PALETTE_DEPTH));
    cmd.index    = pixel_index;
    cmd.entry    = {entry_alpha, entry_red, entry_green, entry_blue};
    cmd.last     = last_pixel;
    cmd.use_pal  = 1'b0;
    unique case (alpha_mode)
      ppe_pkg::MODE_SEPARATE:     cmd.alpha = alpha_byte;
      ppe_pkg::MODE_SEP_INVERTED: cmd.alpha = ppe_pkg::ALPHA_FULL - alpha_byte;
      ppe_pkg::MODE_PAL_INVERTED: begin
        cmd.alpha   = ppe_pkg::ALPHA_FULL;
        cmd.use_pal = 1'b1;
      end
      ppe_pkg::MODE_PACKED: begin
        cmd.alpha = alpha_byte[bit_position] ? ppe_pkg::ALPHA_FULL : ppe_pkg::ALPHA_NONE;
      end
      default:                    cmd.alpha = ppe_pkg::ALPHA_FULL;
    endcase
  end

  // The counter only moves on pixels; the last pixel of an image restarts it.
  always_comb begin
    bit_position_next = bit_position;
    if (accept && is_pixel) begin
      if (last_pixel) begin
        bit_position_next = '0;
      end else if (alpha_mode == ppe_pkg::MODE_PACKED) begin
        bit_position_next = bit_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode   <= ppe_pkg::MODE_OPAQUE;
      bit_position <= '0;
    end else begin
      bit_position <= bit_position_next;
      if (alpha_mode_we) begin
        alpha_mode <= ppe_pkg::alpha_mode_t'(alpha_mode_wdata);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/ppe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppe_back: palette store and pixel expansion
// Takes commands from the queue, writes or reads the palette memory and
// forms the result beat combinationally from the registered read data.
// ----------------------------------------------------------------------------
module ppe_back #(
  parameter int PALETTE_DEPTH = ppe_pkg::PALETTE_DEPTH_DEF,
  parameter int RES_DEPTH     = ppe_pkg::RES_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_empty,
  input  wire ppe_pkg::cmd_t                 cmd,
  output logic                               cmd_pop,
  input  wire logic [$clog2(RES_DEPTH+1)-1:0] res_count,
  output logic                               res_push,
  output ppe_pkg::res_t                      res
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = $clog2(RES_DEPTH+1);

  logic [31:0] palette [PALETTE_DEPTH];
  logic [31:0] rd_data;
  logic        s1_valid;
  logic        s1_in_range;
  logic        s1_use_pal;
  logic [7:0]  s1_alpha;
  logic        s1_last;
  logic        room;
  logic [31:0] entry;

  // A pixel is issued only if the output queue can take it, counting the one
  // already in flight.
  assign room    = ({1'b0, res_count} + (CW+1)'(s1_valid)) < (CW+1)'(RES_DEPTH);
  assign cmd_pop = !cmd_empty && (!cmd.is_pixel || room);

  always_ff @(posedge clk) begin
    if (cmd_pop && !cmd.is_pixel && cmd.in_range) begin
      palette[cmd.index[AW-1:0]] <= cmd.entry;
    end
    if (cmd_pop && cmd.is_pixel) begin
      rd_data <= palette[cmd.index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_in_range <= cmd.in_range;
      s1_use_pal  <= cmd.use_pal;
      s1_alpha    <= cmd.alpha;
      s1_last     <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop && cmd.is_pixel;
    end
  end

  always_comb begin
    entry     = s1_in_range ? rd_data : 32'h0;
    res_push  = s1_valid;
    res.blue  = entry[7:0];
    res.green = entry[15:8];
    res.red   = entry[23:16];
    res.alpha = s1_use_pal ? (ppe_pkg::ALPHA_FULL - entry[31:24]) : s1_alpha;
    res.last  = s1_last;
  end

endmodule
`default_nettype wire

### rtl/palette_pixel_expander_top.sv
`default_nettype none
// A pixel beat passes the command queue, the registered palette read and
// the result queue; palette loads give no result. Throughput while the result
// queue has room: one beat per cycle, set by the single-port palette read.
// Reset clears the queues, the bit counter and the alpha mode (opaque); the
// palette memory keeps its contents and is undefined until loaded.
// ----------------------------------------------------------------------------
// palette_pixel_expander_top: palette index to BGRA pixel expander
// Front stage classifies beats into a command queue; the back stage owns the
// palette memory and fills the result queue.
// ----------------------------------------------------------------------------
module palette_pixel_expander_top #(
  parameter int PALETTE_DEPTH = ppe_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       alpha_mode_we,
  input  wire logic [2:0] alpha_mode_wdata,
  input  wire logic       push,
  output logic            full,
  input  wire logic       operation,
  input  wire logic [7:0] pixel_index,
  input  wire logic [7:0] alpha_byte,
  input  wire logic [7:0] entry_blue,
  input  wire logic [7:0] entry_green,
  input  wire logic [7:0] entry_red,
  input  wire logic [7:0] entry_alpha,
  input  wire logic       last_pixel,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_green,
  output logic [7:0]      out_red,
  output logic [7:0]      out_alpha,
  output logic            out_last
);

  localparam int CMD_W = $bits(ppe_pkg::cmd_t);
  localparam int RES_W = $bits(ppe_pkg::res_t);
  localparam int RCW   = $clog2(ppe_pkg::RES_DEPTH+1);

  logic              accept;
  ppe_pkg::cmd_t     cmd_in;
  logic [CMD_W-1:0]  cmd_raw;
  ppe_pkg::cmd_t     cmd_head;
  logic              cmd_empty;
  logic              cmd_pop;
  logic              res_push;
  ppe_pkg::res_t     res_in;
  logic [RES_W-1:0]  res_raw;
  ppe_pkg::res_t     res_head;
  logic              res_full;
  logic [RCW-1:0]    res_count;

  assign accept   = push && !full;
  assign cmd_head = ppe_pkg::cmd_t'(cmd_raw);
  assign res_head = ppe_pkg::res_t'(res_raw);

  ppe_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .alpha_mode_we    (alpha_mode_we),
    .alpha_mode_wdata (alpha_mode_wdata),
    .accept           (accept),
    .operation        (operation),
    .pixel_index      (pixel_index),
    .alpha_byte       (alpha_byte),
    .entry_blue       (entry_blue),
    .entry_green      (entry_green),
    .entry_red        (entry_red),
    .entry_alpha      (entry_alpha),
    .last_pixel       (last_pixel),
    .cmd              (cmd_in)
  );

  ppe_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (ppe_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_raw),
    .empty     (cmd_empty),
    .count     ()
  );

  ppe_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .RES_DEPTH     (ppe_pkg::RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  ppe_fifo #(
    .WIDTH (RES_W),
    .DEPTH (ppe_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_raw),
    .empty     (empty),
    .count     (res_count)
  );

  assign out_blue  = res_head.blue;
  assign out_green = res_head.green;
  assign out_red   = res_head.red;
  assign out_alpha = res_head.alpha;
  assign out_last  = res_head.last;

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // The issue credit must keep the result queue from overflowing.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result beat pushed into a full queue");

  // Every issued pixel is pushed into the result queue in the following cycle.
  a_pixel_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd_head.is_pixel) |=> res_push)
    else $error("issued pixel produced no result beat");

  // Palette loads never produce a result beat.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && !cmd_head.is_pixel) |=> !res_push)
    else $error("palette load produced a result beat");

endmodule
`default_nettype wire
